/* rtl/core/tlbpt_pkg.sv */
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared sizes and types of the TLB translator: address split, TLB depth,
// frame and free-frame counter widths, and the controller command word.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

	// Channel and address geometry
	localparam int VA_WIDTH     = 16;
	localparam int PA_WIDTH     = 16;
	localparam int OFFSET_WIDTH = 8;

	// TLB and page table sizes (page count is a power of two)
	localparam int TLB_ENTRIES  = 16;
	localparam int PAGE_COUNT   = 256;

	localparam int TLB_IDX_W    = $clog2(TLB_ENTRIES);
	localparam int PAGE_W       = $clog2(PAGE_COUNT);
	localparam int FRAME_W      = PAGE_W;
	localparam int FREE_W       = PAGE_W + 1;

	// Command word from the controller to the datapath
	typedef struct packed {
		logic capture;  // request taken: latch address, start table read
		logic commit;   // finish lookup: update state, load result
	} tlbpt_cmd_t;

	// Page number of a virtual address: bits above the offset, modulo page count
	function automatic logic [PAGE_W-1:0] page_of(input logic [VA_WIDTH-1:0] va);
		logic [VA_WIDTH-1:0] shifted;
		shifted = va >> OFFSET_WIDTH;
		return PAGE_W'(shifted);
	endfunction

endpackage

/* rtl/core/tlbpt_va_if.sv */
// ----------------------------------------------------------------------------
// tlbpt_va_if
// Request channel: one virtual address per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tlbpt_va_if;
	import tlbpt_pkg::*;

	logic                valid;
	logic                ready;
	logic [VA_WIDTH-1:0] virtual_address;

	modport source (output valid, output virtual_address, input ready);
	modport sink   (input valid, input virtual_address, output ready);

endinterface

/* rtl/core/tlbpt_pa_if.sv */
// ----------------------------------------------------------------------------
// tlbpt_pa_if
// Result channel: physical address with TLB hit and page fault flags.
// ----------------------------------------------------------------------------
interface tlbpt_pa_if;
	import tlbpt_pkg::*;

	logic                valid;
	logic                ready;
	logic [PA_WIDTH-1:0] phys_addr;
	logic                tlb_hit;
	logic                page_fault;

	modport source (output valid, output phys_addr, output tlb_hit,
		output page_fault, input ready);
	modport sink   (input valid, input phys_addr, input tlb_hit,
		input page_fault, output ready);

endinterface

/* rtl/core/tlbpt_ram.sv */
// ----------------------------------------------------------------------------
// tlbpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/tlbpt_ctrl.sv */
// ----------------------------------------------------------------------------
// tlbpt_ctrl
// Controller: takes a request, runs the lookup cycle, and owns the result
// valid flag so that a waiting result does not block the next request.
// ----------------------------------------------------------------------------
module tlbpt_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output tlbpt_pkg::tlbpt_cmd_t  cmd
);
	import tlbpt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LOOK = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// Accept in idle; finish once the result register is free or being drained
	assign in_ready    = (state_q == S_IDLE);
	assign cmd.capture = (state_q == S_IDLE) && in_valid;
	assign cmd.commit  = (state_q == S_LOOK) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.capture) state_d = S_LOOK;
			end
			S_LOOK: begin
				if (cmd.commit) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A result that is not taken stays valid
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q)
		else $error("result dropped before it was taken");

	// A taken request always leads to the lookup cycle
	a_capture_look: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_LOOK)
		else $error("request taken without lookup");

	// Never finish a lookup over an untaken result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !out_valid_q || out_ready)
		else $error("result register overwritten");

endmodule

/* rtl/core/tlbpt_datapath.sv */
// ----------------------------------------------------------------------------
// tlbpt_datapath
// TLB entries with parallel tag compare, page table valid bits and frame RAM,
// free-frame counter, FIFO refill pointer and the result register.
// ----------------------------------------------------------------------------
module tlbpt_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tlbpt_pkg::tlbpt_cmd_t           cmd,
	input  logic [tlbpt_pkg::VA_WIDTH-1:0]  virtual_address,
	output logic [tlbpt_pkg::PA_WIDTH-1:0]  phys_addr,
	output logic                            tlb_hit,
	output logic                            page_fault
);
	import tlbpt_pkg::*;

	// TLB entries
	logic [PAGE_W-1:0]      tlb_tag_q   [TLB_ENTRIES];
	logic [FRAME_W-1:0]     tlb_frame_q [TLB_ENTRIES];
	logic [TLB_ENTRIES-1:0] tlb_valid_q;
	logic [TLB_IDX_W-1:0]   fifo_q;

	// Page table valid bits and free-frame counter
	logic [PAGE_COUNT-1:0]  tbl_valid_q;
	logic [FREE_W-1:0]      nff_q;

	// Captured request
	logic [PAGE_W-1:0]       page_q;
	logic [OFFSET_WIDTH-1:0] offset_q;

	// Result register
	logic [PA_WIDTH-1:0]    pa_q;
	logic                   hit_q;
	logic                   fault_q;

	// Lookup signals
	logic [FRAME_W-1:0]     ram_rdata;
	logic                   hit;
	logic [FRAME_W-1:0]     hit_frame;
	logic                   tbl_hit;
	logic                   fault;
	logic [FRAME_W-1:0]     frame;
	logic [FRAME_W+OFFSET_WIDTH-1:0] pa_wide;

	// Frame store of the page table, read when a request is taken
	tlbpt_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (PAGE_COUNT)
	) u_frame_ram (
		.clk   (clk),
		.we    (cmd.commit && fault),
		.waddr (page_q),
		.wdata (frame),
		.re    (cmd.capture),
		.raddr (page_of(virtual_address)),
		.rdata (ram_rdata)
	);

	// Search TLB, lowest matching entry wins
	always_comb begin
		hit       = 1'b0;
		hit_frame = '0;
		for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
			if (tlb_valid_q[k] && (tlb_tag_q[k] == page_q)) begin
				hit       = 1'b1;
				hit_frame = tlb_frame_q[k];
			end
		end
	end

	// Resolve frame on a miss from the table or the next free frame
	assign tbl_hit = tbl_valid_q[page_q];
	assign fault   = !hit && !tbl_hit;
	assign frame   = hit ? hit_frame : (tbl_hit ? ram_rdata : nff_q[PAGE_W-1:0]);
	assign pa_wide = {frame, offset_q};

	// Latch the request address
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			page_q   <= page_of(virtual_address);
			offset_q <= virtual_address[OFFSET_WIDTH-1:0];
		end
	end

	// Load the result
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			pa_q    <= PA_WIDTH'(pa_wide);
			hit_q   <= hit;
			fault_q <= fault;
		end
	end

	// Refill TLB entry contents at the FIFO pointer on a miss
	always_ff @(posedge clk) begin
		if (cmd.commit && !hit) begin
			tlb_tag_q[fifo_q]   <= page_q;
			tlb_frame_q[fifo_q] <= frame;
		end
	end

	// Advance valid bits, FIFO pointer and free-frame counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlb_valid_q <= '0;
			fifo_q      <= '0;
			tbl_valid_q <= '0;
			nff_q       <= '0;
		end else if (cmd.commit) begin
			if (!hit) begin
				tlb_valid_q[fifo_q] <= 1'b1;
				fifo_q <= (fifo_q == TLB_IDX_W'(TLB_ENTRIES - 1)) ? '0 : fifo_q + 1'b1;
			end
			if (fault) begin
				tbl_valid_q[page_q] <= 1'b1;
				if (nff_q != FREE_W'(PAGE_COUNT)) begin
					nff_q <= nff_q + 1'b1;
				end
			end
		end
	end

	assign phys_addr  = pa_q;
	assign tlb_hit    = hit_q;
	assign page_fault = fault_q;

	// A fault never comes from a TLB hit
	a_fault_not_hit: assert property (@(posedge clk)
		cmd.commit && hit |-> !fault)
		else $error("page fault reported on TLB hit");

	// A faulting page is present in the table afterwards
	a_fault_maps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && fault |=> tbl_valid_q[$past(page_q)])
		else $error("faulting page not recorded in table");

	// A miss installs the page in the TLB
	a_miss_refills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && !hit |=> tlb_valid_q[$past(fifo_q)])
		else $error("TLB not refilled after miss");

endmodule

/* rtl/core/tlb_page_table_translator.sv */
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Each request passes accept and lookup states, the result register loading
// at commit; only idle takes a request. The page table frame RAM read is
// issued at accept, TLB compare plus write-back follow.
// A pending result does not block the next request unless still untaken
// at the end of that request's lookup cycle.
// Reset: asynchronous, clears TLB and table valid bits, FIFO pointer and
// free-frame counter; no clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
module tlb_page_table_translator (
	input  logic         clk,
	input  logic         arst_n,
	tlbpt_va_if.sink     addr_req,
	tlbpt_pa_if.source   xlat_rsp
);
	import tlbpt_pkg::*;

	tlbpt_cmd_t cmd;

	// Handshake and sequencing
	tlbpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (addr_req.valid),
		.in_ready  (addr_req.ready),
		.out_valid (xlat_rsp.valid),
		.out_ready (xlat_rsp.ready),
		.cmd       (cmd)
	);

	// Translation state and result
	tlbpt_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.virtual_address (addr_req.virtual_address),
		.phys_addr       (xlat_rsp.phys_addr),
		.tlb_hit         (xlat_rsp.tlb_hit),
		.page_fault      (xlat_rsp.page_fault)
	);

endmodule

/* tb/tlbpt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_checker
// Watches the address and translation channels, keeps its own copy of the
// TLB, page table and free-frame counter, predicts each translation and
// compares it with the result the block returns, in order.
// ----------------------------------------------------------------------------
module tlbpt_checker (
	input  logic clk,
	input  logic arst_n,
	tlbpt_va_if  addr_mon,
	tlbpt_pa_if  xlat_mon,
	output int   mismatches,
	output int   pending
);
	import tlbpt_pkg::*;

	typedef struct packed {
		logic [PA_WIDTH-1:0] phys_addr;
		logic                tlb_hit;
		logic                page_fault;
	} xlat_t;

	// Shadow TLB, page table and allocation state
	logic [PAGE_W-1:0]    tlb_page   [TLB_ENTRIES];
	logic [FRAME_W-1:0]   tlb_frm    [TLB_ENTRIES];
	logic                 tlb_live   [TLB_ENTRIES];
	logic [FRAME_W-1:0]   pt_frame   [PAGE_COUNT];
	logic                 pt_live    [PAGE_COUNT];
	logic [FREE_W-1:0]    free_count;
	logic [TLB_IDX_W-1:0] victim_ptr;

	xlat_t expected_xlats[$];

	initial mismatches = 0;

	// Translate one address and update the shadow state as the block does
	function automatic xlat_t translate(input logic [VA_WIDTH-1:0] va);
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
		logic [31:0]        wide;
		xlat_t              res;
		page       = PAGE_W'(va >> OFFSET_WIDTH);
		frame      = '0;
		res        = '0;
		// lowest matching valid entry wins
		for (int k = 0; k < TLB_ENTRIES; k++) begin
			if (!res.tlb_hit && tlb_live[k] && tlb_page[k] == page) begin
				frame       = tlb_frm[k];
				res.tlb_hit = 1'b1;
			end
		end
		if (!res.tlb_hit) begin
			if (pt_live[page]) begin
				frame = pt_frame[page];
			end else begin
				// demand paging: hand out the next free frame, counter saturates
				res.page_fault = 1'b1;
				frame          = FRAME_W'(free_count);
				if (free_count < FREE_W'(PAGE_COUNT))
					free_count = free_count + 1'b1;
				pt_frame[page] = frame;
				pt_live[page]  = 1'b1;
			end
			// refill in FIFO order
			tlb_page[victim_ptr] = page;
			tlb_frm[victim_ptr]  = frame;
			tlb_live[victim_ptr] = 1'b1;
			victim_ptr           = victim_ptr + 1'b1;
		end
		wide = (32'(frame) << OFFSET_WIDTH) | 32'(va[OFFSET_WIDTH-1:0]);
		res.phys_addr = wide[PA_WIDTH-1:0];
		return res;
	endfunction

	// Check results before queuing new requests of the same edge
	always @(posedge clk or negedge arst_n) begin
		xlat_t got;
		xlat_t want;
		if (!arst_n) begin
			for (int k = 0; k < TLB_ENTRIES; k++) begin
				tlb_page[k] = '0;
				tlb_frm[k]  = '0;
				tlb_live[k] = 1'b0;
			end
			for (int p = 0; p < PAGE_COUNT; p++) begin
				pt_frame[p] = '0;
				pt_live[p]  = 1'b0;
			end
			free_count = '0;
			victim_ptr = '0;
			expected_xlats.delete();
			pending <= 0;
		end else begin
			if (xlat_mon.valid && xlat_mon.ready) begin
				got = '{xlat_mon.phys_addr, xlat_mon.tlb_hit, xlat_mon.page_fault};
				if (expected_xlats.size() == 0) begin
					$display("%0t: unexpected translation pa=%h hit=%b fault=%b",
						$time, got.phys_addr, got.tlb_hit, got.page_fault);
					mismatches++;
				end else begin
					want = expected_xlats.pop_front();
					if (got !== want) begin
						$display({"%0t: translation expected pa=%h hit=%b fault=%b",
							" actual pa=%h hit=%b fault=%b"},
							$time, want.phys_addr, want.tlb_hit, want.page_fault,
							got.phys_addr, got.tlb_hit, got.page_fault);
						mismatches++;
					end
				end
			end
			if (addr_mon.valid && addr_mon.ready)
				expected_xlats.push_back(translate(addr_mon.virtual_address));
			pending <= expected_xlats.size();
		end
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives virtual addresses into the TLB translator and throttles its result
// channel; the checker beside the block predicts and compares. Directed
// addresses cover offset and page extremes, FIFO refill and wrap, and table
// hits after eviction; random traffic mixes a working set with scattered and
// sweeping pages.
// ----------------------------------------------------------------------------
module testbench;
	import tlbpt_pkg::*;

	localparam int RANDOM_ITEMS = 1630;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HOLD_CYCLES  = 300;

	localparam logic [VA_WIDTH-1:0] DIRECTED_VA [21] = '{
		16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00, 16'h5AA5, 16'hA55A,
		16'h0101, 16'h0202, 16'h0304, 16'h0408, 16'h0510, 16'h0620,
		16'h0740, 16'h0880, 16'h09FE, 16'h0AFD, 16'h0BFB, 16'h0CF7,
		16'h0D7F, 16'h0080, 16'h0DBF
	};

	logic clk;
	logic arst_n;
	int   mismatches;
	int   pending;
	int   cycle_count;
	bit   hold_off_req;
	bit   rsp_always_ready;
	bit   burst;

	logic [PAGE_W-1:0] work_set [8];
	logic [PAGE_W-1:0] sweep_page;

	tlbpt_va_if addr_req ();
	tlbpt_pa_if xlat_rsp ();

	tlb_page_table_translator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.addr_req (addr_req),
		.xlat_rsp (xlat_rsp)
	);

	tlbpt_checker checker_inst (
		.clk        (clk),
		.arst_n     (arst_n),
		.addr_mon   (addr_req),
		.xlat_mon   (xlat_rsp),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Idle length: mostly short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(3, 1);
		if (r < 98) return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// Pick an address: working set for hits, scattered and sweeping pages for misses
	function automatic logic [VA_WIDTH-1:0] next_address();
		int                r;
		logic [PAGE_W-1:0] page;
		r = $urandom_range(99);
		if ($urandom_range(9) == 0)
			work_set[$urandom_range(7)] = PAGE_W'($urandom);
		if (r < 55) begin
			page = work_set[$urandom_range(7)];
		end else if (r < 80) begin
			page = PAGE_W'($urandom);
		end else begin
			page       = sweep_page;
			sweep_page = sweep_page + 1'b1;
		end
		return {page, OFFSET_WIDTH'($urandom)};
	endfunction

	// Offer one request and hold it until taken
	task automatic send_request(input logic [VA_WIDTH-1:0] va);
		@(negedge clk);
		addr_req.valid           <= 1'b1;
		addr_req.virtual_address <= va;
		@(posedge clk);
		while (!addr_req.ready) @(posedge clk);
	endtask

	// Drop valid for a number of cycles
	task automatic idle_gap(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			addr_req.valid           <= 1'b0;
			addr_req.virtual_address <= VA_WIDTH'($urandom);
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// Stop sending until every translation has come back
	task automatic drain();
		idle_gap(1);
		while (pending != 0) @(negedge clk);
	endtask

	// Hard limit on run length
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tlb_page_table_translator regression: fail");
		$finish;
	end

	// Result side: random stalls, full-speed stretches, one long hold-off
	initial begin
		xlat_rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				xlat_rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (rsp_always_ready) begin
				xlat_rsp.ready <= 1'b1;
			end else if ($urandom_range(99) < 2) begin
				xlat_rsp.ready <= 1'b0;
				repeat ($urandom_range(40, 10)) @(negedge clk);
			end else begin
				xlat_rsp.ready <= ($urandom_range(99) < 70);
			end
		end
	end

	// Request side and verdict
	initial begin
		addr_req.valid           = 1'b0;
		addr_req.virtual_address = '0;
		hold_off_req             = 1'b0;
		rsp_always_ready         = 1'b0;
		burst                    = 1'b0;
		sweep_page               = '0;
		foreach (work_set[i]) work_set[i] = PAGE_W'($urandom);
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, FIFO fill and wrap, table hit after eviction
		foreach (DIRECTED_VA[i]) begin
			send_request(DIRECTED_VA[i]);
			idle_gap(gap_len());
		end
		drain();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 200 == 0) begin
				burst            = ($urandom_range(2) == 0);
				rsp_always_ready = burst;
			end
			// long result stall while requests keep coming
			if (n == 400) begin
				burst            = 1'b1;
				rsp_always_ready = 1'b0;
				hold_off_req     = 1'b1;
			end
			if (n == 900 || n == 1300)
				drain();
			send_request(next_address());
			if (!burst)
				idle_gap(gap_len());
		end

		idle_gap(1);
		rsp_always_ready = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("tlb_page_table_translator regression: pass");
		else
			$display("tlb_page_table_translator regression: fail");
		$finish;
	end

endmodule
